// ===== hdl/arc_pkg.sv =====
// Package holding the reply patterns, command kinds, verdict codes and the match functions.
`default_nettype none
package arc_pkg;

  localparam int unsigned WIN_DEPTH = 35;
  localparam int unsigned PAT_COUNT = 20;
  localparam int unsigned PAT_CHARS = WIN_DEPTH + 1;
  localparam int unsigned AGE_W = $clog2(PAT_CHARS);

  typedef logic [PAT_COUNT-1:0] pat_vec_t;
  typedef logic [AGE_W-1:0] age_t;

  typedef enum logic [3:0] {
    MODE_TEST      = 4'd0,
    MODE_ECHO      = 4'd1,
    MODE_APN       = 4'd2,
    MODE_SENDDATA  = 4'd3,
    MODE_PIN       = 4'd4,
    MODE_REG       = 4'd5,
    MODE_ATTACH    = 4'd6,
    MODE_NETQUERY  = 4'd7,
    MODE_WAITMSG   = 4'd8,
    MODE_NETOPEN   = 4'd9,
    MODE_SOCKOPEN  = 4'd10,
    MODE_SOCKSEND  = 4'd11,
    MODE_SOCKCLOSE = 4'd12,
    MODE_NETCLOSE  = 4'd13
  } mode_t;

  typedef enum logic [1:0] {
    V_OK   = 2'd0,
    V_FAIL = 2'd1,
    V_WAIT = 2'd2
  } verdict_t;

  localparam int unsigned P_OK          = 0;
  localparam int unsigned P_ERROR       = 1;
  localparam int unsigned P_CPIN_READY  = 2;
  localparam int unsigned P_CREG_01     = 3;
  localparam int unsigned P_CREG_05     = 4;
  localparam int unsigned P_CREG_00     = 5;
  localparam int unsigned P_CREG_02     = 6;
  localparam int unsigned P_CREG_03     = 7;
  localparam int unsigned P_CREG_04     = 8;
  localparam int unsigned P_CGATT_1     = 9;
  localparam int unsigned P_CGATT_0     = 10;
  localparam int unsigned P_NETOPEN_0   = 11;
  localparam int unsigned P_NETOPEN_1   = 12;
  localparam int unsigned P_IP_ERROR    = 13;
  localparam int unsigned P_CIPOPEN_00  = 14;
  localparam int unsigned P_CIPOPEN_01  = 15;
  localparam int unsigned P_PROMPT      = 16;
  localparam int unsigned P_CIPCLOSE_00 = 17;
  localparam int unsigned P_NETCLOSE_0  = 18;
  localparam int unsigned P_NETCLOSE_2  = 19;

  // Strings are right-justified, so the final character sits in the low byte.
  localparam logic [8*PAT_CHARS-1:0] PAT_TEXT [PAT_COUNT] = '{
    "OK",
    "ERROR",
    "+CPIN: READY",
    "+CREG: 0,1",
    "+CREG: 0,5",
    "+CREG: 0,0",
    "+CREG: 0,2",
    "+CREG: 0,3",
    "+CREG: 0,4",
    "+CGATT: 1",
    "+CGATT: 0",
    "+NETOPEN: 0",
    "+NETOPEN: 1",
    "+IP ERROR: Network is already opened",
    "+CIPOPEN: 0,0",
    "+CIPOPEN: 0,1",
    ">",
    "+CIPCLOSE: 0,0",
    "+NETCLOSE: 0",
    "+NETCLOSE: 2"
  };

  localparam age_t PAT_LEN [PAT_COUNT] = '{
    6'd2, 6'd5, 6'd12, 6'd10, 6'd10, 6'd10, 6'd10, 6'd10, 6'd10, 6'd9,
    6'd9, 6'd11, 6'd11, 6'd36, 6'd13, 6'd13, 6'd1, 6'd14, 6'd12, 6'd12
  };

  // A byte that lies age places behind the newest one agrees with every pattern
  // that is too short to reach it, and otherwise with the matching character.
  function automatic pat_vec_t char_match(logic [7:0] b, age_t age);
    pat_vec_t m;
    for (int i = 0; i < PAT_COUNT; i++) begin
      if (age >= PAT_LEN[i]) begin
        m[i] = 1'b1;
      end else begin
        m[i] = (b == PAT_TEXT[i][8*age +: 8]);
      end
    end
    return m;
  endfunction

  function automatic verdict_t pick(logic ok, logic fail);
    verdict_t v;
    if (ok) begin
      v = V_OK;
    end else if (fail) begin
      v = V_FAIL;
    end else begin
      v = V_WAIT;
    end
    return v;
  endfunction

  function automatic verdict_t decide(logic [3:0] mode, pat_vec_t s);
    verdict_t v;
    case (mode)
      MODE_TEST, MODE_ECHO, MODE_APN, MODE_SENDDATA: v = pick(s[P_OK], s[P_ERROR]);
      MODE_PIN:       v = pick(s[P_CPIN_READY], s[P_ERROR]);
      MODE_REG: begin
        if (s[P_CREG_01] || s[P_CREG_05]) begin
          v = V_OK;
        end else if (s[P_CREG_00] || s[P_CREG_02]) begin
          v = V_WAIT;
        end else if (s[P_CREG_03] || s[P_CREG_04]) begin
          v = V_FAIL;
        end else begin
          v = V_WAIT;
        end
      end
      MODE_ATTACH:    v = pick(s[P_CGATT_1], s[P_CGATT_0]);
      MODE_NETQUERY:  v = pick(s[P_NETOPEN_0], s[P_NETOPEN_1]);
      MODE_NETOPEN:   v = pick(s[P_NETOPEN_0], s[P_IP_ERROR]);
      MODE_SOCKOPEN:  v = pick(s[P_CIPOPEN_00], s[P_CIPOPEN_01]);
      MODE_SOCKSEND:  v = pick(s[P_PROMPT], s[P_ERROR]);
      MODE_SOCKCLOSE: v = pick(s[P_CIPCLOSE_00], s[P_ERROR]);
      MODE_NETCLOSE:  v = pick(s[P_NETCLOSE_0], s[P_NETCLOSE_2]);
      default:        v = V_WAIT;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/arc_if.sv =====
// Handshake interfaces for the response byte channel and the verdict channel.
`default_nettype none
interface arc_byte_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, output mode, output byte_value, output last, input ready);
  modport sink (input valid, input mode, input byte_value, input last, output ready);
endinterface

interface arc_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink (input valid, input verdict, output ready);
endinterface
`default_nettype wire

// ===== hdl/arc_cell.sv =====
// One window cell: holds a byte, passes it on to the older neighbour and compares it.
`default_nettype none
module arc_cell (
  input  wire                logic             clk,
  input  wire                logic             rst,
  input  wire                logic             shift,
  input  wire                logic             clear,
  input  wire                arc_pkg::age_t    age,
  input  wire                logic [7:0]       byte_in,
  output                     logic [7:0]       byte_out,
  output                     arc_pkg::pat_vec_t match
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held <= 8'd0;
    end else if (shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;
  assign match    = arc_pkg::char_match(held, age);

endmodule
`default_nettype wire

// ===== hdl/at_response_classifier_core.sv =====
// Top level of the modem response classifier: cell chain, found flags and verdict output.
//
// Usage: the response arrives one byte per transfer on resp_byte, each tagged
// with the command kind (mode); last marks the final byte. Every byte is
// compared in the transfer cycle against all reply patterns, using the new
// byte and a chain of 35 cells that hold the previous bytes. A zero byte ends
// the string; it and later bytes of the same response are ignored.
// On the transfer of the last byte a verdict (0 ok, 1 fail, 2 wait) is
// computed from the found flags and the command kind, and is registered
// for result. The window, flags and end mark are then cleared, so the next
// response may start in the very next cycle.
// Throughput is one byte per cycle while ready is high. The verdict sits in an
// output register backed by one skid register: while the receiver stalls, bytes
// keep being taken until a second verdict waits, and then resp_byte.ready falls until
// result drains. Reset clears the window, the flags and both verdict registers.
`default_nettype none
module at_response_classifier_core (
  input  wire logic          clk,
  input  wire logic          rst,
  arc_byte_if.sink           resp_byte,
  arc_verdict_if.source      result
);

  localparam int unsigned N = arc_pkg::WIN_DEPTH;

  logic [7:0]         chain [N+1];
  arc_pkg::pat_vec_t  cell_match [N];
  arc_pkg::pat_vec_t  hit;
  arc_pkg::pat_vec_t  seen;
  arc_pkg::pat_vec_t  seen_next;
  logic               string_ended;
  logic               take;
  logic               active;
  logic               shift;
  logic               finish;
  arc_pkg::verdict_t  verdict_next;

  logic               out_valid;
  logic [1:0]         out_data;
  logic               skid_valid;
  logic [1:0]         skid_data;
  logic               pop;

  assign resp_byte.ready = !skid_valid;
  assign take   = resp_byte.valid && resp_byte.ready;
  assign active = !string_ended && (resp_byte.byte_value != 8'd0);
  assign shift  = take && active;
  assign finish = take && resp_byte.last;

  assign chain[0] = resp_byte.byte_value;

  for (genvar g = 0; g < N; g++) begin : g_cell
    arc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .clear    (finish),
      .age      (arc_pkg::age_t'(g + 1)),
      .byte_in  (chain[g]),
      .byte_out (chain[g+1]),
      .match    (cell_match[g])
    );
  end

  always_comb begin
    hit = arc_pkg::char_match(resp_byte.byte_value, '0);
    for (int k = 0; k < N; k++) begin
      hit = hit & cell_match[k];
    end
    seen_next    = active ? (seen | hit) : seen;
    verdict_next = arc_pkg::decide(resp_byte.mode, seen_next);
  end

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      seen         <= '0;
      string_ended <= 1'b0;
    end else if (take) begin
      seen <= seen_next;
      if (resp_byte.byte_value == 8'd0) begin
        string_ended <= 1'b1;
      end
    end
  end

  assign pop = out_valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop && skid_valid) begin
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= finish;
      if (finish) begin
        out_data <= verdict_next;
      end
    end else if (finish) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
        skid_data  <= verdict_next;
      end else begin
        out_valid <= 1'b1;
        out_data  <= verdict_next;
      end
    end
  end

  assign result.valid   = out_valid;
  assign result.verdict = out_data;

endmodule
`default_nettype wire

// ===== tb/tb_at_response_classifier_core.sv =====
// Testbench for the modem response classifier, with directed and random responses.
`default_nettype none
module tb_at_response_classifier_core;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASE_BYTES = 165;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned NEAR_COUNT = 11;
  localparam logic [3:0] MODE_NONE_LO = 4'd14;
  localparam logic [3:0] MODE_NONE_HI = 4'd15;

  class verdict_tracker;
    string reply_text [arc_pkg::PAT_COUNT];
    byte unsigned recent [$];
    bit [arc_pkg::PAT_COUNT-1:0] found;
    bit ended;
    arc_pkg::verdict_t verdicts_due [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned tally [3];

    function new();
      reply_text = '{"OK", "ERROR", "+CPIN: READY", "+CREG: 0,1", "+CREG: 0,5",
                     "+CREG: 0,0", "+CREG: 0,2", "+CREG: 0,3", "+CREG: 0,4",
                     "+CGATT: 1", "+CGATT: 0", "+NETOPEN: 0", "+NETOPEN: 1",
                     "+IP ERROR: Network is already opened", "+CIPOPEN: 0,0",
                     "+CIPOPEN: 0,1", ">", "+CIPCLOSE: 0,0", "+NETCLOSE: 0",
                     "+NETCLOSE: 2"};
    endfunction

    function arc_pkg::verdict_t choose(bit ok, bit fail);
      if (ok) begin
        return arc_pkg::V_OK;
      end
      if (fail) begin
        return arc_pkg::V_FAIL;
      end
      return arc_pkg::V_WAIT;
    endfunction

    function arc_pkg::verdict_t classify(logic [3:0] m);
      case (m)
        arc_pkg::MODE_TEST, arc_pkg::MODE_ECHO, arc_pkg::MODE_APN, arc_pkg::MODE_SENDDATA:
          return choose(found[arc_pkg::P_OK], found[arc_pkg::P_ERROR]);
        arc_pkg::MODE_PIN:
          return choose(found[arc_pkg::P_CPIN_READY], found[arc_pkg::P_ERROR]);
        arc_pkg::MODE_REG: begin
          if (found[arc_pkg::P_CREG_01] || found[arc_pkg::P_CREG_05]) begin
            return arc_pkg::V_OK;
          end
          if (found[arc_pkg::P_CREG_00] || found[arc_pkg::P_CREG_02]) begin
            return arc_pkg::V_WAIT;
          end
          if (found[arc_pkg::P_CREG_03] || found[arc_pkg::P_CREG_04]) begin
            return arc_pkg::V_FAIL;
          end
          return arc_pkg::V_WAIT;
        end
        arc_pkg::MODE_ATTACH:
          return choose(found[arc_pkg::P_CGATT_1], found[arc_pkg::P_CGATT_0]);
        arc_pkg::MODE_NETQUERY:
          return choose(found[arc_pkg::P_NETOPEN_0], found[arc_pkg::P_NETOPEN_1]);
        arc_pkg::MODE_NETOPEN:
          return choose(found[arc_pkg::P_NETOPEN_0], found[arc_pkg::P_IP_ERROR]);
        arc_pkg::MODE_SOCKOPEN:
          return choose(found[arc_pkg::P_CIPOPEN_00], found[arc_pkg::P_CIPOPEN_01]);
        arc_pkg::MODE_SOCKSEND:
          return choose(found[arc_pkg::P_PROMPT], found[arc_pkg::P_ERROR]);
        arc_pkg::MODE_SOCKCLOSE:
          return choose(found[arc_pkg::P_CIPCLOSE_00], found[arc_pkg::P_ERROR]);
        arc_pkg::MODE_NETCLOSE:
          return choose(found[arc_pkg::P_NETCLOSE_0], found[arc_pkg::P_NETCLOSE_2]);
        default:
          return arc_pkg::V_WAIT;
      endcase
    endfunction

    // Every reply ends at the newest byte when it matches, so only suffixes are compared.
    function void take_byte(logic [3:0] m, logic [7:0] b, logic is_last);
      int len;
      bit hit;
      if (!ended) begin
        if (b == 8'h00) begin
          ended = 1'b1;
        end else begin
          recent.push_back(b);
          if (recent.size() > arc_pkg::PAT_CHARS) begin
            void'(recent.pop_front());
          end
          for (int i = 0; i < arc_pkg::PAT_COUNT; i++) begin
            len = reply_text[i].len();
            if (len <= recent.size()) begin
              hit = 1'b1;
              for (int k = 0; k < len; k++) begin
                if (recent[recent.size() - len + k] != reply_text[i][k]) begin
                  hit = 1'b0;
                end
              end
              if (hit) begin
                found[i] = 1'b1;
              end
            end
          end
        end
      end
      if (is_last) begin
        verdicts_due.push_back(classify(m));
        recent.delete();
        found = '0;
        ended = 1'b0;
      end
    endfunction

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("Mismatch at %0t: %s", $time, what);
      end
    endfunction

    function void check_verdict(logic [1:0] got);
      arc_pkg::verdict_t want;
      if (verdicts_due.size() == 0) begin
        note_mismatch($sformatf("verdict %0d arrived with none expected", got));
      end else begin
        want = verdicts_due.pop_front();
        checked++;
        tally[want]++;
        if (got !== want) begin
          note_mismatch($sformatf("verdict expected %0d (%s), actual %0d",
                                  want, want.name(), got));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  arc_byte_if byte_ch ();
  arc_verdict_if verdict_ch ();
  verdict_tracker tracker = new();

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  bit hold_req;
  bit hold_ack;
  int unsigned hold_left;

  string near_miss [NEAR_COUNT] = '{"+CREG: 0,6", "+CGATT: 2", "+NETOPEN: 2", "+CIPOPEN: 0,2",
                                     "+CIPCLOSE: 0,1", "+NETCLOSE: 1", "ERRO", "O",
                                     "+CPIN: SIM PIN", "+IP ERROR: Network is not opened",
                                     "\015\012"};

  at_response_classifier_core dut (
    .clk(clk),
    .rst(rst),
    .resp_byte(byte_ch),
    .result(verdict_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      tracker.take_byte(byte_ch.mode, byte_ch.byte_value, byte_ch.last);
    end
    if (!rst && verdict_ch.valid && verdict_ch.ready) begin
      tracker.check_verdict(verdict_ch.verdict);
    end
  end

  // The receiver also serves long hold-offs, requested by toggling hold_req.
  initial begin
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        verdict_ch.ready <= 1'b0;
      end else begin
        verdict_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic void add_text(ref byte unsigned q [$], input string s);
    for (int i = 0; i < s.len(); i++) begin
      q.push_back(s[i]);
    end
  endfunction

  function automatic string pick_fragment(logic [3:0] m);
    int unsigned roll;
    int unsigned idx;
    roll = $urandom_range(99);
    if (roll < 25) begin
      return near_miss[$urandom_range(NEAR_COUNT - 1)];
    end
    if (roll < 45) begin
      return tracker.reply_text[$urandom_range(arc_pkg::PAT_COUNT - 1)];
    end
    case (m)
      arc_pkg::MODE_TEST, arc_pkg::MODE_ECHO, arc_pkg::MODE_APN, arc_pkg::MODE_SENDDATA:
        idx = $urandom_range(1) ? arc_pkg::P_OK : arc_pkg::P_ERROR;
      arc_pkg::MODE_PIN:
        idx = $urandom_range(1) ? arc_pkg::P_CPIN_READY : arc_pkg::P_ERROR;
      arc_pkg::MODE_REG:
        idx = $urandom_range(arc_pkg::P_CREG_04, arc_pkg::P_CREG_01);
      arc_pkg::MODE_ATTACH:
        idx = $urandom_range(1) ? arc_pkg::P_CGATT_1 : arc_pkg::P_CGATT_0;
      arc_pkg::MODE_NETQUERY:
        idx = $urandom_range(1) ? arc_pkg::P_NETOPEN_0 : arc_pkg::P_NETOPEN_1;
      arc_pkg::MODE_NETOPEN:
        idx = $urandom_range(1) ? arc_pkg::P_NETOPEN_0 : arc_pkg::P_IP_ERROR;
      arc_pkg::MODE_SOCKOPEN:
        idx = $urandom_range(1) ? arc_pkg::P_CIPOPEN_00 : arc_pkg::P_CIPOPEN_01;
      arc_pkg::MODE_SOCKSEND:
        idx = $urandom_range(1) ? arc_pkg::P_PROMPT : arc_pkg::P_ERROR;
      arc_pkg::MODE_SOCKCLOSE:
        idx = $urandom_range(1) ? arc_pkg::P_CIPCLOSE_00 : arc_pkg::P_ERROR;
      arc_pkg::MODE_NETCLOSE:
        idx = $urandom_range(1) ? arc_pkg::P_NETCLOSE_0 : arc_pkg::P_NETCLOSE_2;
      default:
        idx = $urandom_range(arc_pkg::PAT_COUNT - 1);
    endcase
    return tracker.reply_text[idx];
  endfunction

  task automatic send_bytes(input logic [3:0] body_mode, input logic [3:0] last_mode,
                            input byte unsigned text [$]);
    for (int i = 0; i < text.size(); i++) begin
      while ($urandom_range(99) < idle_pct) begin
        byte_ch.valid <= 1'b0;
        @(posedge clk);
      end
      byte_ch.valid <= 1'b1;
      byte_ch.mode <= (i == text.size() - 1) ? last_mode : body_mode;
      byte_ch.byte_value <= text[i];
      byte_ch.last <= (i == text.size() - 1);
      @(posedge clk);
      while (!byte_ch.ready) begin
        @(posedge clk);
      end
      bytes_sent++;
    end
  endtask

  task automatic send_text(input logic [3:0] m, input string s);
    byte unsigned q [$];
    add_text(q, s);
    send_bytes(m, m, q);
  endtask

  task automatic send_random_response();
    logic [3:0] m;
    logic [3:0] body;
    byte unsigned q [$];
    int unsigned pos;
    m = 4'($urandom_range(15));
    body = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : m;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(12, 1)) begin
        q.push_back(8'($urandom_range(255, 1)));
      end
    end else begin
      repeat ($urandom_range(3, 1)) begin
        repeat ($urandom_range(3)) begin
          q.push_back(8'($urandom_range(255, 1)));
        end
        add_text(q, pick_fragment(m));
      end
    end
    if ($urandom_range(9) == 0) begin
      pos = $urandom_range(q.size() - 1);
      q.insert(pos, 8'h00);
    end else if ($urandom_range(19) == 0) begin
      q.push_back(8'h00);
    end
    send_bytes(body, m, q);
  endtask

  initial begin
    byte unsigned q [$];
    int unsigned phase_start;
    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.mode <= arc_pkg::MODE_TEST;
    byte_ch.byte_value <= 8'h00;
    byte_ch.last <= 1'b0;
    idle_pct = 0;
    stall_pct <= 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_text(arc_pkg::MODE_TEST, "OK");
    send_text(MODE_NONE_LO, "OK");
    q = '{8'hFF};
    send_bytes(MODE_NONE_HI, MODE_NONE_HI, q);
    send_text(arc_pkg::MODE_WAITMSG, "OK");
    send_text(arc_pkg::MODE_SOCKSEND, ">");
    // A reply split over two responses must not be found.
    send_text(arc_pkg::MODE_TEST, "O");
    send_text(arc_pkg::MODE_TEST, "K");
    q = '{"O", "K", 8'h00};
    send_bytes(arc_pkg::MODE_TEST, arc_pkg::MODE_TEST, q);
    q = '{8'h00, "O", "K"};
    send_bytes(arc_pkg::MODE_TEST, arc_pkg::MODE_TEST, q);
    q = '{8'h00};
    send_bytes(arc_pkg::MODE_TEST, arc_pkg::MODE_TEST, q);
    q.delete();
    add_text(q, "ERROR");
    send_bytes(arc_pkg::MODE_TEST, arc_pkg::MODE_PIN, q);
    q = '{8'h01, 8'h80};
    send_bytes(arc_pkg::MODE_ECHO, arc_pkg::MODE_ECHO, q);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          hold_req <= ~hold_req;
        end
        1: begin
          idle_pct = 54;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 54;
        end
        default: begin
          idle_pct = 35;
          stall_pct <= 35;
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        send_random_response();
      end
    end
    byte_ch.valid <= 1'b0;

    while (tracker.verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in directed cases and four idling phases, %0d-cycle hold-off.",
             bytes_sent, HOLD_CYCLES);
    $display("Checked %0d verdicts (ok %0d, fail %0d, wait %0d): %0d mismatches, %0d missing.",
             tracker.checked, tracker.tally[arc_pkg::V_OK], tracker.tally[arc_pkg::V_FAIL],
             tracker.tally[arc_pkg::V_WAIT], tracker.mismatches, tracker.verdicts_due.size());
    if (tracker.mismatches == 0 && tracker.verdicts_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
